/* sv/array_list_insert_delete_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the array list insert/delete block
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_DELETE_ASSERT_SVH
`define ARRAY_LIST_INSERT_DELETE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ALI_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ALI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ali_pkg.sv */
// ----------------------------------------------------------------------------
// ali_pkg
// Types and fixed field widths of the array list insert/delete block.
// ----------------------------------------------------------------------------
package ali_pkg;

   localparam int FUNC_W   = 2;
   localparam int POS_W    = 8;
   localparam int VALUE_W  = 32;
   localparam int LEN_W    = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_POS  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT_UP,
      ST_WRITE,
      ST_SHIFT_DOWN,
      ST_READ_WAIT
   } state_type;

endpackage

/* sv/ali_ram.sv */
// ----------------------------------------------------------------------------
// ali_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ali_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/array_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete
// Ordered list of signed words kept in one RAM, with insert, delete and read.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge with start high and busy low.
// req_func selects insert, delete or read; req_position is the list position
// and req_value the word to insert. Each command gives exactly one result,
// shown for one cycle with rsp_valid high; the receiver cannot stall it.
// rsp_list_length is the length after the command, rsp_read_value the word
// of a successful read and zero otherwise.
// Rejected commands and reads need no shift. An insert or a delete moves the
// entries behind its position, one entry per cycle through the single RAM
// write port, each read from the registered read port ahead of its write.
// Reset clears the length and the sequencer; RAM contents stay undefined
// and are only read below the length, where every entry has been written.
// busy is high while a shift, the final insert write or a read is under way.
// ----------------------------------------------------------------------------
module array_list_insert_delete #(
   parameter int LIST_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ali_pkg::FUNC_W-1:0]          req_func,
   input  logic [ali_pkg::POS_W-1:0]           req_position,
   input  logic signed [ali_pkg::VALUE_W-1:0]  req_value,
   output logic                                rsp_valid,
   output logic [ali_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ali_pkg::LEN_W-1:0]           rsp_list_length,
   output logic signed [ali_pkg::VALUE_W-1:0]  rsp_read_value
);

   localparam int ADDR_W = $clog2(LIST_DEPTH);
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > ali_pkg::POS_W) ? CNT_W : ali_pkg::POS_W;

   ali_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]   cursor_ff, cursor_in;
   logic [ali_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ali_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [ali_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ali_pkg::VALUE_W-1:0] ram_wr_data;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ali_pkg::VALUE_W-1:0] ram_rd_data;

   logic                accept;
   logic [CMP_W-1:0]    pos_ext, pos_next_ext, cnt_ext;
   logic                pos_lt_cnt, pos_le_cnt, pos_eq_cnt, pos_is_last, list_full;
   logic [ADDR_W-1:0]   cnt_last;

   assign busy   = (state_ff != ali_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign pos_ext      = CMP_W'(req_position);
   assign pos_next_ext = pos_ext + 1'b1;
   assign cnt_ext      = CMP_W'(count_ff);
   assign pos_lt_cnt   = (pos_ext < cnt_ext);
   assign pos_le_cnt   = (pos_ext <= cnt_ext);
   assign pos_eq_cnt   = (pos_ext == cnt_ext);
   assign pos_is_last  = (pos_next_ext == cnt_ext);
   assign list_full    = (count_ff == CNT_W'(LIST_DEPTH));
   assign cnt_last     = ADDR_W'(count_ff - 1'b1);

   ali_ram #(
      .WIDTH (ali_pkg::VALUE_W),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ali_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  ali_pkg::FUNC_INSERT: begin
                     if (pos_le_cnt && !list_full) begin
                        state_in = pos_eq_cnt ? ali_pkg::ST_WRITE : ali_pkg::ST_SHIFT_UP;
                     end
                  end
                  ali_pkg::FUNC_DELETE: begin
                     if (pos_lt_cnt && !pos_is_last) begin
                        state_in = ali_pkg::ST_SHIFT_DOWN;
                     end
                  end
                  ali_pkg::FUNC_READ: begin
                     if (pos_lt_cnt) begin
                        state_in = ali_pkg::ST_READ_WAIT;
                     end
                  end
                  default: state_in = ali_pkg::ST_IDLE;
               endcase
            end
         end
         ali_pkg::ST_SHIFT_UP: begin
            if (cursor_ff == pos_ff) begin
               state_in = ali_pkg::ST_WRITE;
            end
         end
         ali_pkg::ST_WRITE:     state_in = ali_pkg::ST_IDLE;
         ali_pkg::ST_SHIFT_DOWN: begin
            if (cursor_ff == cnt_last) begin
               state_in = ali_pkg::ST_IDLE;
            end
         end
         ali_pkg::ST_READ_WAIT: state_in = ali_pkg::ST_IDLE;
         default:               state_in = ali_pkg::ST_IDLE;
      endcase
   end

   // Datapath, RAM control and result.
   // The shifts read one entry ahead of the write, so in a shift cycle the read
   // and write addresses differ by one or two and never collide.
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      cursor_in     = cursor_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ali_pkg::STATUS_OK;
      rsp_value_in  = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cursor_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_addr   = cursor_ff;
      unique case (state_ff)
         ali_pkg::ST_IDLE: begin
            if (accept) begin
               pos_in   = ADDR_W'(req_position);
               value_in = req_value;
               unique case (req_func)
                  ali_pkg::FUNC_INSERT: begin
                     if (!pos_le_cnt) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ali_pkg::STATUS_POS;
                     end else if (list_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ali_pkg::STATUS_FULL;
                     end else if (!pos_eq_cnt) begin
                        ram_rd_addr = cnt_last;
                        cursor_in   = cnt_last;
                     end
                  end
                  ali_pkg::FUNC_DELETE: begin
                     if (!pos_lt_cnt) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ali_pkg::STATUS_POS;
                     end else if (pos_is_last) begin
                        count_in     = count_ff - 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        ram_rd_addr = ADDR_W'(pos_next_ext);
                        cursor_in   = ADDR_W'(pos_next_ext);
                     end
                  end
                  ali_pkg::FUNC_READ: begin
                     if (!pos_lt_cnt) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ali_pkg::STATUS_POS;
                     end else begin
                        ram_rd_addr = ADDR_W'(req_position);
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ali_pkg::STATUS_POS;
                  end
               endcase
            end
         end
         ali_pkg::ST_SHIFT_UP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cursor_ff + 1'b1;
            ram_rd_addr = cursor_ff - 1'b1;
            cursor_in   = cursor_ff - 1'b1;
         end
         ali_pkg::ST_WRITE: begin
            ram_wr_en    = 1'b1;
            ram_wr_addr  = pos_ff;
            ram_wr_data  = value_ff;
            count_in     = count_ff + 1'b1;
            rsp_valid_in = 1'b1;
         end
         ali_pkg::ST_SHIFT_DOWN: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cursor_ff - 1'b1;
            if (cursor_ff == cnt_last) begin
               count_in     = count_ff - 1'b1;
               rsp_valid_in = 1'b1;
            end else begin
               ram_rd_addr = cursor_ff + 1'b1;
               cursor_in   = cursor_ff + 1'b1;
            end
         end
         ali_pkg::ST_READ_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = ram_rd_data;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ali_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      cursor_ff     <= cursor_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_list_length = ali_pkg::LEN_W'(CMP_W'(count_ff));
   assign rsp_read_value  = rsp_value_ff;

endmodule

/* sv/ali_checker.sv */
// ----------------------------------------------------------------------------
// ali_checker
// Port-level checks of the array list insert/delete block, bound to the top.
// ----------------------------------------------------------------------------
`include "array_list_insert_delete_assert.svh"

module ali_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [ali_pkg::FUNC_W-1:0]          req_func,
   input logic [ali_pkg::POS_W-1:0]           req_position,
   input logic signed [ali_pkg::VALUE_W-1:0]  req_value,
   input logic                                rsp_valid,
   input logic [ali_pkg::STATUS_W-1:0]        rsp_status,
   input logic [ali_pkg::LEN_W-1:0]           rsp_list_length,
   input logic signed [ali_pkg::VALUE_W-1:0]  rsp_read_value
);

   logic [ali_pkg::FUNC_W+ali_pkg::POS_W+ali_pkg::VALUE_W-1:0] req_bus;
   assign req_bus = {req_func, req_position, req_value};

   // A command either completes at once or holds the block busy.
   `ALI_ASSERT_NEXT(a_accept_answered, clock, reset, start && !busy, busy || rsp_valid, "accepted command neither answered nor busy")

   // Every result closes its command, so the block is free when it shows.
   `ALI_ASSERT_IMPLY(a_result_idle, clock, reset, rsp_valid, !busy, "result shown while busy")

   // A failed command carries no word.
   `ALI_ASSERT_IMPLY(a_value_zero, clock, reset, rsp_valid && rsp_status != ali_pkg::STATUS_OK, rsp_read_value == 0, "failed command returned a nonzero word")

   // The length moves only together with a result transfer.
   `ALI_ASSERT_IMPLY(a_length_stable, clock, reset, !rsp_valid && !$past(reset) && req_bus == req_bus, $stable(rsp_list_length), "length changed without a result")

endmodule

bind array_list_insert_delete ali_checker u_ali_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_func        (req_func),
   .req_position    (req_position),
   .req_value       (req_value),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_list_length (rsp_list_length),
   .rsp_read_value  (rsp_read_value)
);

/* bench/array_list_insert_delete_test.sv */
// ----------------------------------------------------------------------------
// array_list_insert_delete_test
// Self-checking bench for the array list block. The bench keeps its own copy
// of the list as a queue and predicts status, length and read word for every
// command transfer. Some directed commands cover the edge cases. Random phases
// then fill the list to full, drain it to empty and mix all operations, with
// idle gaps of random length between commands.
// ----------------------------------------------------------------------------
module array_list_insert_delete_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH = 128;
   localparam int RANDOM_ITEMS = 950;
   localparam int PHASE_ITEMS = 190;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;
   // The block has no name for the fourth function code; it must be rejected.
   localparam logic [ali_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_EVEN
   } op_mix_type;

   typedef struct {
      ali_pkg::status_type                 status;
      logic [ali_pkg::LEN_W-1:0]           length;
      logic signed [ali_pkg::VALUE_W-1:0]  word;
   } list_reply_type;

   class list_shadow;
      logic signed [ali_pkg::VALUE_W-1:0] words[$];
      list_reply_type                     due[$];
      int failures = 0;
      int checked = 0;
      int commands = 0;
      int inserts = 0;
      int deletes = 0;
      int reads = 0;
      int pos_errors = 0;
      int overflows = 0;
      int peak = 0;

      function void report(string msg);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
      endfunction

      // Applies one accepted command to the shadow list and queues its reply.
      function void note_command(logic [ali_pkg::FUNC_W-1:0] func,
                                 logic [ali_pkg::POS_W-1:0] pos,
                                 logic signed [ali_pkg::VALUE_W-1:0] value);
         list_reply_type r;
         int n;
         n = words.size();
         r.status = ali_pkg::STATUS_POS;
         r.word = '0;
         commands++;
         case (func)
            ali_pkg::FUNC_INSERT: begin
               if (pos <= n) begin
                  if (n >= LIST_DEPTH) begin
                     r.status = ali_pkg::STATUS_FULL;
                  end else begin
                     words.insert(pos, value);
                     r.status = ali_pkg::STATUS_OK;
                     inserts++;
                  end
               end
            end
            ali_pkg::FUNC_DELETE: begin
               if (pos < n) begin
                  words.delete(pos);
                  r.status = ali_pkg::STATUS_OK;
                  deletes++;
               end
            end
            ali_pkg::FUNC_READ: begin
               if (pos < n) begin
                  r.word = words[pos];
                  r.status = ali_pkg::STATUS_OK;
                  reads++;
               end
            end
            default: ;
         endcase
         if (r.status == ali_pkg::STATUS_POS)
            pos_errors++;
         else if (r.status == ali_pkg::STATUS_FULL)
            overflows++;
         r.length = ali_pkg::LEN_W'(words.size());
         if (words.size() > peak)
            peak = words.size();
         due.push_back(r);
      endfunction

      function void check_reply(logic [ali_pkg::STATUS_W-1:0] status,
                                logic [ali_pkg::LEN_W-1:0] length,
                                logic signed [ali_pkg::VALUE_W-1:0] word);
         list_reply_type r;
         if (due.size() == 0) begin
            report($sformatf("unexpected result: status %0d length %0d value %0d",
                             status, length, word));
            return;
         end
         r = due.pop_front();
         checked++;
         if (status !== r.status || length !== r.length || word !== r.word)
            report($sformatf({"mismatch: expected status %0d length %0d value %0d,",
                              " got status %0d length %0d value %0d"},
                             r.status, r.length, r.word, status, length, word));
      endfunction

      function void flush_leftovers();
         while (due.size() != 0) begin
            report($sformatf("missing result: status %0d length %0d value %0d",
                             due[0].status, due[0].length, due[0].word));
            void'(due.pop_front());
         end
      endfunction
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 start = 1'b0;
   logic                                 busy;
   logic [ali_pkg::FUNC_W-1:0]           req_func = ali_pkg::FUNC_READ;
   logic [ali_pkg::POS_W-1:0]            req_position = '0;
   logic signed [ali_pkg::VALUE_W-1:0]   req_value = '0;
   logic                                 rsp_valid;
   logic [ali_pkg::STATUS_W-1:0]         rsp_status;
   logic [ali_pkg::LEN_W-1:0]            rsp_list_length;
   logic signed [ali_pkg::VALUE_W-1:0]   rsp_read_value;

   list_shadow board = new();
   bit         no_idle = 1'b0;
   int         cycles = 0;

   array_list_insert_delete #(
      .LIST_DEPTH(LIST_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_list_length(rsp_list_length),
      .rsp_read_value(rsp_read_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("array_list_insert_delete_test NOT OK");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_reply(rsp_status, rsp_list_length, rsp_read_value);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (no_idle || r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   // Drives one command and returns once it has been transferred.
   task automatic issue(logic [ali_pkg::FUNC_W-1:0] func, logic [ali_pkg::POS_W-1:0] pos,
                        logic signed [ali_pkg::VALUE_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_func <= func;
      req_position <= pos;
      req_value <= value;
      do
         @(posedge clock);
      while (busy);
      board.note_command(func, pos, value);
   endtask

   task automatic random_command(op_mix_type mix);
      int n;
      int r;
      int k;
      logic [ali_pkg::FUNC_W-1:0] f;
      logic [ali_pkg::POS_W-1:0] p;
      logic signed [ali_pkg::VALUE_W-1:0] v;
      n = board.words.size();
      r = $urandom_range(99);
      case (mix)
         MIX_GROW:   f = r < 85 ? ali_pkg::FUNC_INSERT : r < 90 ? ali_pkg::FUNC_DELETE :
                         r < 98 ? ali_pkg::FUNC_READ : FUNC_UNUSED;
         MIX_SHRINK: f = r < 10 ? ali_pkg::FUNC_INSERT : r < 85 ? ali_pkg::FUNC_DELETE :
                         r < 98 ? ali_pkg::FUNC_READ : FUNC_UNUSED;
         default:    f = r < 35 ? ali_pkg::FUNC_INSERT : r < 65 ? ali_pkg::FUNC_DELETE :
                         r < 98 ? ali_pkg::FUNC_READ : FUNC_UNUSED;
      endcase
      k = $urandom_range(99);
      if (k < 8)
         p = ali_pkg::POS_W'($urandom_range(255));
      else if (f == ali_pkg::FUNC_INSERT)
         p = ali_pkg::POS_W'(k < 20 ? n : k < 30 ? 0 : int'($urandom_range(n)));
      else if (n == 0)
         p = ali_pkg::POS_W'($urandom_range(3));
      else
         p = ali_pkg::POS_W'(k < 20 ? n - 1 : k < 30 ? 0 : int'($urandom_range(n - 1)));
      k = $urandom_range(9);
      v = k == 0 ? 32'h7fff_ffff : k == 1 ? 32'h8000_0000 : $urandom;
      issue(f, p, v);
   endtask

   initial begin
      op_mix_type mix;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Operations on an empty list, a gap past the end and the unused code.
      issue(ali_pkg::FUNC_READ, 8'd0, 32'sd0);
      issue(ali_pkg::FUNC_DELETE, 8'd0, 32'sd0);
      issue(ali_pkg::FUNC_INSERT, 8'd1, 32'sd5);
      issue(FUNC_UNUSED, 8'd0, 32'sd0);
      // Build a short list through front, end and middle inserts.
      issue(ali_pkg::FUNC_INSERT, 8'd0, 32'h7fff_ffff);
      issue(ali_pkg::FUNC_INSERT, 8'd0, 32'h8000_0000);
      issue(ali_pkg::FUNC_INSERT, 8'd2, -32'sd1);
      issue(ali_pkg::FUNC_INSERT, 8'd1, 32'sd0);
      issue(ali_pkg::FUNC_INSERT, 8'd4, 32'h5555_aaaa);
      issue(ali_pkg::FUNC_INSERT, 8'd6, 32'haaaa_5555);
      for (int i = 0; i < 5; i++)
         issue(ali_pkg::FUNC_READ, ali_pkg::POS_W'(i), 32'sd0);
      issue(ali_pkg::FUNC_READ, 8'd5, 32'sd0);
      issue(ali_pkg::FUNC_READ, 8'd255, 32'sd0);
      issue(ali_pkg::FUNC_DELETE, 8'd128, 32'sd0);
      issue(ali_pkg::FUNC_DELETE, 8'd4, 32'sd0);
      issue(ali_pkg::FUNC_DELETE, 8'd0, 32'sd0);
      issue(ali_pkg::FUNC_DELETE, 8'd1, 32'sd0);
      issue(ali_pkg::FUNC_READ, 8'd0, 32'sd0);
      issue(ali_pkg::FUNC_READ, 8'd1, 32'sd0);
      issue(FUNC_UNUSED, 8'd255, -32'sd1);

      // Phases alternate so that the list is driven to full and back to empty.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % PHASE_ITEMS == 0)
            mix = (i / PHASE_ITEMS) % 3 == 2 ? MIX_EVEN :
                  (i / PHASE_ITEMS) % 3 == 1 ? MIX_SHRINK : MIX_GROW;
         if (i % 50 == 0)
            no_idle = $urandom_range(3) == 0;
         random_command(mix);
      end
      @(negedge clock);
      start <= 1'b0;

      while (board.due.size() != 0)
         @(posedge clock);
      repeat (LIST_DEPTH + 4) @(posedge clock);
      board.flush_leftovers();

      $display("%0d commands: %0d inserts, %0d deletes, %0d reads done, %0d position errors,",
               board.commands, board.inserts, board.deletes, board.reads, board.pos_errors);
      $display("%0d full-list rejections, longest list %0d, %0d results checked, %0d failures",
               board.overflows, board.peak, board.checked, board.failures);
      if (board.failures == 0)
         $display("array_list_insert_delete_test OK");
      else
         $display("array_list_insert_delete_test NOT OK");
      $finish;
   end

endmodule

/* array_list_insert_delete.f */
+incdir+sv
sv/ali_pkg.sv
sv/ali_ram.sv
sv/array_list_insert_delete.sv
sv/ali_checker.sv
bench/array_list_insert_delete_test.sv
